### src/pol_pkg.sv
// Package with the types, codes and sizes shared by the positional ordered list.
`timescale 1ns / 1ps
`default_nettype none
package pol_pkg;

	// Capacity of the list and the widths that follow from it.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int DATA_W   = 32;

	// Action codes of an input item.
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_GET    = 2'd2,
		ACT_LOCATE = 2'd3
	} action_t;

	// Status codes of a result item.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// One result as it passes from the sequencer to the output register.
	typedef struct packed {
		status_t                    status;
		logic signed [DATA_W-1:0]   read_value;
		logic        [POS_W-1:0]    found_position;
		logic        [POS_W-1:0]    list_length;
	} result_t;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

endpackage
`default_nettype wire

### src/pol_if.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface pol_req_if;
	import pol_pkg::*;

	logic                     valid;
	logic                     ready;
	logic        [1:0]        action;
	logic        [POS_W-1:0]  position;
	logic signed [DATA_W-1:0] item_value;

	modport source (output valid, output action, output position, output item_value,
		input ready);
	modport sink (input valid, input action, input position, input item_value,
		output ready);
endinterface

interface pol_rsp_if;
	import pol_pkg::*;

	logic                     valid;
	logic                     ready;
	logic        [1:0]        status;
	logic signed [DATA_W-1:0] read_value;
	logic        [POS_W-1:0]  found_position;
	logic        [POS_W-1:0]  list_length;

	modport source (output valid, output status, output read_value,
		output found_position, output list_length, input ready);
	modport sink (input valid, input status, input read_value,
		input found_position, input list_length, output ready);
endinterface
`default_nettype wire

### src/pol_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pol_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### src/pol_ctrl.sv
// Sequencer that checks each request and walks the element memory to serve those that pass.
`timescale 1ns / 1ps
`default_nettype none
module pol_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output      logic                    req_ready,
	input  wire logic [1:0]              req_action,
	input  wire logic [pol_pkg::POS_W-1:0]  req_position,
	input  wire logic [pol_pkg::DATA_W-1:0] req_item_value,
	output      logic                    res_valid,
	input  wire logic                    res_ready,
	output      pol_pkg::result_t        res
);
	import pol_pkg::*;

	state_t              state_q;
	action_t             act_q;
	logic [DATA_W-1:0]   val_q;
	logic [IDX_W-1:0]    ins_idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    rem_q;
	status_t             status_q;
	logic [DATA_W-1:0]   readv_q;
	logic [CNT_W-1:0]    found_q;
	logic                pend_s1;
	logic [IDX_W-1:0]    addr_s1;

	logic [CMP_W-1:0]    pos_w;
	logic [CMP_W-1:0]    cnt_w;
	logic [CMP_W-1:0]    pm1_w;
	logic                take;
	logic                take_walk;
	status_t             take_status;
	logic [IDX_W-1:0]    take_ptr;
	logic [CNT_W-1:0]    take_rem;
	logic                issue;
	logic                match;
	logic                walk_end;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [DATA_W-1:0]   ram_wdata;
	logic [DATA_W-1:0]   ram_rdata;
	logic [CMP_W-1:0]    found_w;
	logic [CMP_W-1:0]    len_w;

	pol_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// Widened copies of position and length for the range checks.
	assign pos_w = CMP_W'(req_position);
	assign cnt_w = CMP_W'(cnt_q);
	assign pm1_w = pos_w - 1'b1;
	assign take  = req_valid && req_ready;

	assign req_ready = (state_q == S_IDLE);

	// Request decode: initial status, whether a walk is needed, and where it starts.
	always_comb begin
		take_walk   = 1'b0;
		take_status = ST_OK;
		take_ptr    = '0;
		take_rem    = '0;
		case (action_t'(req_action))
			ACT_INSERT: begin
				if ((pos_w == '0) || (pos_w > cnt_w + 1'b1)) begin
					take_status = ST_BAD_POS;
				end else if (cnt_w == CMP_W'(CAPACITY)) begin
					take_status = ST_FULL;
				end else begin
					take_walk = 1'b1;
				end
				take_ptr = IDX_W'(cnt_q - 1'b1);
				take_rem = CNT_W'(cnt_w - pm1_w);
			end
			ACT_DELETE: begin
				if ((pos_w == '0) || (pos_w > cnt_w)) begin
					take_status = ST_BAD_POS;
				end else begin
					take_walk = 1'b1;
				end
				take_ptr = IDX_W'(pos_w);
				take_rem = CNT_W'(cnt_w - pos_w);
			end
			ACT_GET: begin
				if ((pos_w == '0) || (pos_w > cnt_w)) begin
					take_status = ST_BAD_POS;
				end else begin
					take_walk = 1'b1;
				end
				take_ptr = IDX_W'(pm1_w);
				take_rem = CNT_W'(1);
			end
			default: begin
				take_status = ST_NOT_FOUND;
				take_walk   = 1'b1;
				take_rem    = cnt_q;
			end
		endcase
	end

	// Walk control: a read goes out while entries remain and no match has been seen.
	assign match    = (state_q == S_WALK) && pend_s1 && (act_q == ACT_LOCATE)
		&& (ram_rdata == val_q);
	assign issue    = (state_q == S_WALK) && (rem_q != '0) && !match;
	assign walk_end = (state_q == S_WALK) && (((rem_q == '0) && !pend_s1) || match);

	// Write port: shifted entries while walking, the new value at the end of an insert.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		if ((state_q == S_WALK) && pend_s1) begin
			case (act_q)
				ACT_INSERT: begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1 + 1'b1;
				end
				ACT_DELETE: begin
					ram_we    = 1'b1;
					ram_waddr = addr_s1 - 1'b1;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end else if (walk_end && (act_q == ACT_INSERT)) begin
			ram_we    = 1'b1;
			ram_waddr = ins_idx_q;
			ram_wdata = val_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (take) begin
						state_q <= take_walk ? S_WALK : S_DONE;
					end
				end
				S_WALK: begin
					pend_s1 <= issue;
					if (walk_end) begin
						state_q <= S_DONE;
						case (act_q)
							ACT_INSERT: cnt_q <= cnt_q + 1'b1;
							ACT_DELETE: cnt_q <= cnt_q - 1'b1;
							default:    cnt_q <= cnt_q;
						endcase
					end
				end
				S_DONE: begin
					pend_s1 <= 1'b0;
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Request capture, walk pointers and the result fields.
	always_ff @(posedge clk) begin
		if (take) begin
			act_q     <= action_t'(req_action);
			val_q     <= req_item_value;
			ins_idx_q <= IDX_W'(pm1_w);
			readv_q   <= '0;
			found_q   <= '0;
			status_q  <= take_status;
			ptr_q     <= take_ptr;
			rem_q     <= take_rem;
		end else if (state_q == S_WALK) begin
			if (issue) begin
				rem_q   <= rem_q - 1'b1;
				addr_s1 <= ptr_q;
				if (act_q == ACT_INSERT) begin
					ptr_q <= ptr_q - 1'b1;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (pend_s1 && (act_q == ACT_GET)) begin
				readv_q <= ram_rdata;
			end
			if (match) begin
				status_q <= ST_OK;
				found_q  <= CNT_W'(addr_s1) + 1'b1;
			end
		end
	end

	// Result towards the output register.
	assign found_w            = CMP_W'(found_q);
	assign len_w              = CMP_W'(cnt_q);
	assign res_valid          = (state_q == S_DONE);
	assign res.status         = status_q;
	assign res.read_value     = readv_q;
	assign res.found_position = found_w[POS_W-1:0];
	assign res.list_length    = len_w[POS_W-1:0];

endmodule
`default_nettype wire

### src/positional_ordered_list.sv
// Positional ordered list: top level with the output register.
// A rejected request goes from idle straight to the done state; insert, delete, get and locate
// first walk the element memory (a locate stops at its first hit), and every result then passes
// through the output register. Throughput: one request at a time; the walk reads one entry per
// cycle through the single read port of the element memory, so the entries walked set it.
// Reset: arst_n empties the list at once; the memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module positional_ordered_list (
	input  wire logic clk,
	input  wire logic arst_n,
	pol_req_if.sink   req,
	pol_rsp_if.source rsp
);
	import pol_pkg::*;

	logic    res_valid;
	logic    res_ready;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	pol_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req.valid),
		.req_ready      (req.ready),
		.req_action     (req.action),
		.req_position   (req.position),
		.req_item_value (req.item_value),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res)
	);

	// The output register takes a new result when empty or being drained.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// Result channel.
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_q.status;
	assign rsp.read_value     = out_q.read_value;
	assign rsp.found_position = out_q.found_position;
	assign rsp.list_length    = out_q.list_length;

endmodule
`default_nettype wire
